// File: rtl/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg - skyline rectangle allocator shared types
// Field widths, controller states and the command/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package sra_pkg;

  localparam int RECT_W     = 8;  // rect_width / rect_height
  localparam int PAGE_IDX_W = 2;  // page_index
  localparam int POS_W      = 7;  // pos_x / pos_y

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAGE_INIT,
    ST_WIN_READ,
    ST_WIN_WAIT,
    ST_EVAL,
    ST_PICK,
    ST_PAGE_DONE,
    ST_OPEN,
    ST_RAISE
  } sra_state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic page_first;
    logic page_next;
    logic page_init;
    logic win_read;
    logic eval;
    logic pick;
    logic open_page;
    logic raise;
    logic emit_ok;
    logic emit_fail;
  } sra_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic req_bad;
    logic none_open;
    logic i_last;
    logic x_last;
    logic found;
    logic page_last;
    logic pages_full;
  } sra_stat_t;

endpackage

// File: rtl/skyline_rect_allocator_core.sv
// Reset: a clearing pass zeroes all MAX_PAGES * 2**ceil(log2(PAGE_WIDTH)) skyline entries
//   (512 at defaults) with busy high; no pages in use.
// Sequence: a size refusal gives a registered done after accept. Each searched page
//   scans every start column, one skyline read a cycle; a new page may then be opened
//   before the raise, and a registered done follows, also after a refusal on full pages.
// Throughput: one request at a time, the next taken in the done cycle; receiver cannot stall.
// ----------------------------------------------------------------------------
// skyline_rect_allocator_core - skyline rectangle allocator
// Places rectangles on square atlas pages by least-waste skyline search.
// ----------------------------------------------------------------------------
module skyline_rect_allocator_core import sra_pkg::*; #(
  parameter int PAGE_WIDTH  = 128,
  parameter int PAGE_HEIGHT = 128,
  parameter int MAX_PAGES   = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [RECT_W-1:0]     rect_width,
  input  logic [RECT_W-1:0]     rect_height,
  output logic                  done,
  output logic                  granted,
  output logic [PAGE_IDX_W-1:0] page_index,
  output logic [POS_W-1:0]      pos_x,
  output logic [POS_W-1:0]      pos_y
);

  sra_cmd_t  cmd;
  sra_stat_t stat;

  sra_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  sra_dpath #(
    .PAGE_WIDTH  (PAGE_WIDTH),
    .PAGE_HEIGHT (PAGE_HEIGHT),
    .MAX_PAGES   (MAX_PAGES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .cmd         (cmd),
    .stat        (stat),
    .done        (done),
    .granted     (granted),
    .page_index  (page_index),
    .pos_x       (pos_x),
    .pos_y       (pos_y)
  );

`ifndef SYNTH
  // a result is only ever presented once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // an accepted request either starts a search or is refused at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request dropped");

  // a refusal carries no placement
  a_refuse_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !granted) |-> (page_index == '0 && pos_x == '0 && pos_y == '0))
    else $error("refused request with placement fields set");

  // a granted result needs the request to have been taken first
  a_emit_after_work: assert property (@(posedge clk) disable iff (rst)
    (done && granted) |-> $past(busy))
    else $error("grant without a search");
`endif

endmodule

// File: rtl/sra_ram.sv
// ----------------------------------------------------------------------------
// sra_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/sra_ctrl.sv
// ----------------------------------------------------------------------------
// sra_ctrl - allocator sequencer
// Clears the skyline after reset, then walks pages and start columns for
// each request and commands the datapath step by step.
// ----------------------------------------------------------------------------
module sra_ctrl import sra_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  sra_stat_t stat,
  output sra_cmd_t  cmd
);

  sra_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (stat.req_bad) begin
            cmd.emit_fail = 1'b1;
          end else begin
            cmd.load       = 1'b1;
            cmd.page_first = 1'b1;
            state_next     = stat.none_open ? ST_OPEN : ST_PAGE_INIT;
          end
        end
      end
      ST_PAGE_INIT: begin
        cmd.page_init = 1'b1;
        state_next    = ST_WIN_READ;
      end
      ST_WIN_READ: begin
        cmd.win_read = 1'b1;
        if (stat.i_last) begin
          state_next = ST_WIN_WAIT;
        end
      end
      ST_WIN_WAIT: begin
        // last column of the span lands in the accumulators here
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_PICK;
      end
      ST_PICK: begin
        cmd.pick   = 1'b1;
        state_next = stat.x_last ? ST_PAGE_DONE : ST_WIN_READ;
      end
      ST_PAGE_DONE: begin
        if (stat.found) begin
          state_next = ST_RAISE;
        end else if (!stat.page_last) begin
          cmd.page_next = 1'b1;
          state_next    = ST_PAGE_INIT;
        end else if (stat.pages_full) begin
          cmd.emit_fail = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          state_next = ST_OPEN;
        end
      end
      ST_OPEN: begin
        cmd.open_page = 1'b1;
        state_next    = ST_RAISE;
      end
      ST_RAISE: begin
        cmd.raise = 1'b1;
        if (stat.i_last) begin
          cmd.emit_ok = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/sra_dpath.sv
// ----------------------------------------------------------------------------
// sra_dpath - allocator datapath
// Holds the skyline memory, the page and column counters, the span
// max/sum accumulators, the best-span record and the result registers.
// ----------------------------------------------------------------------------
module sra_dpath import sra_pkg::*; #(
  parameter int PAGE_WIDTH  = 128,
  parameter int PAGE_HEIGHT = 128,
  parameter int MAX_PAGES   = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [RECT_W-1:0]     rect_width,
  input  logic [RECT_W-1:0]     rect_height,
  input  sra_cmd_t              cmd,
  output sra_stat_t             stat,
  output logic                  done,
  output logic                  granted,
  output logic [PAGE_IDX_W-1:0] page_index,
  output logic [POS_W-1:0]      pos_x,
  output logic [POS_W-1:0]      pos_y
);

  localparam int CW    = $clog2(PAGE_WIDTH);
  localparam int HW    = $clog2(PAGE_HEIGHT + 1);
  localparam int PGW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int POW   = $clog2(MAX_PAGES + 1);
  localparam int AW    = PGW + CW;
  localparam int DEPTH = MAX_PAGES << CW;
  localparam int XW    = ((CW > RECT_W) ? CW : RECT_W) + 1;
  localparam int YW    = ((HW > RECT_W) ? HW : RECT_W) + 1;
  localparam int SW    = RECT_W + HW;

  localparam logic [AW-1:0]  CLR_LAST  = AW'(DEPTH - 1);
  localparam logic [XW-1:0]  PW_LIM    = XW'(PAGE_WIDTH);
  localparam logic [YW-1:0]  PH_LIM    = YW'(PAGE_HEIGHT);
  localparam logic [POW-1:0] PAGES_LIM = POW'(MAX_PAGES);

  logic [AW-1:0]     clr_addr;
  logic [RECT_W-1:0] w_q, h_q;
  logic [PGW-1:0]    page;
  logic [POW-1:0]    pages_open;
  logic [CW-1:0]     x;
  logic [RECT_W-1:0] i;
  logic              rd_vld;
  logic [HW-1:0]     tmax;
  logic [SW-1:0]     tsum;
  logic [SW-1:0]     area;
  logic              fits;
  logic              found;
  logic [SW-1:0]     least_waste;
  logic [CW-1:0]     best_x;
  logic [HW-1:0]     best_y;

  logic [CW-1:0]     col_base;
  logic [CW-1:0]     col;
  logic [HW-1:0]     level;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [HW-1:0]     ram_wdata;
  logic [HW-1:0]     ram_rdata;

  assign col_base = cmd.raise ? best_x : x;
  assign col      = CW'(XW'(col_base) + XW'(i));
  assign level    = HW'(YW'(best_y) + YW'(h_q));

  assign ram_we    = cmd.clr_step | cmd.raise;
  assign ram_waddr = cmd.clr_step ? clr_addr : {page, col};
  assign ram_wdata = cmd.clr_step ? '0 : level;

  sra_ram #(
    .WIDTH (HW),
    .DEPTH (DEPTH)
  ) u_tops (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.win_read),
    .raddr ({page, col}),
    .rdata (ram_rdata)
  );

  // status back to the sequencer
  always_comb begin
    stat.clr_last   = (clr_addr == CLR_LAST);
    stat.req_bad    = (rect_width == '0) || (rect_height == '0) ||
                      (XW'(rect_width) > PW_LIM) || (YW'(rect_height) > PH_LIM);
    stat.none_open  = (pages_open == '0);
    stat.i_last     = (i == (w_q - 1'b1));
    stat.x_last     = ((XW'(x) + XW'(w_q)) == PW_LIM);
    stat.found      = found;
    stat.page_last  = ((POW'(page) + 1'b1) == pages_open);
    stat.pages_full = (pages_open == PAGES_LIM);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      pages_open <= '0;
      rd_vld     <= 1'b0;
      done       <= 1'b0;
    end else begin
      rd_vld <= cmd.win_read;
      done   <= cmd.emit_ok | cmd.emit_fail;
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.open_page) begin
        pages_open <= pages_open + 1'b1;
      end
    end
  end

  // request, counters and search record
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_q <= rect_width;
      h_q <= rect_height;
    end

    if (cmd.open_page) begin
      page <= pages_open[PGW-1:0];
    end else if (cmd.page_first) begin
      page <= '0;
    end else if (cmd.page_next) begin
      page <= page + 1'b1;
    end

    if (cmd.page_init) begin
      x <= '0;
    end else if (cmd.pick) begin
      x <= x + 1'b1;
    end

    if (cmd.page_init || cmd.pick || cmd.open_page) begin
      i <= '0;
    end else if (cmd.win_read || cmd.raise) begin
      i <= i + 1'b1;
    end

    // running max and sum of the column tops under the span
    if (cmd.page_init || cmd.pick) begin
      tmax <= '0;
      tsum <= '0;
    end else if (rd_vld) begin
      if (ram_rdata > tmax) begin
        tmax <= ram_rdata;
      end
      tsum <= tsum + SW'(ram_rdata);
    end

    if (cmd.eval) begin
      area <= (SW'(w_q) * SW'(tmax)) - tsum;
      fits <= (YW'(tmax) + YW'(h_q)) <= PH_LIM;
    end

    // strict compare keeps the lowest start column on ties
    if (cmd.page_init) begin
      found <= 1'b0;
    end else if (cmd.pick && fits && (!found || (area < least_waste))) begin
      found       <= 1'b1;
      least_waste <= area;
      best_x      <= x;
      best_y      <= tmax;
    end else if (cmd.open_page) begin
      best_x <= '0;
      best_y <= '0;
    end

    if (cmd.emit_ok) begin
      granted    <= 1'b1;
      page_index <= PAGE_IDX_W'(page);
      pos_x      <= POS_W'(best_x);
      pos_y      <= POS_W'(best_y);
    end else if (cmd.emit_fail) begin
      granted    <= 1'b0;
      page_index <= '0;
      pos_x      <= '0;
      pos_y      <= '0;
    end
  end

endmodule

// File: tb/sra_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sra_checker - scoreboard for the skyline rectangle allocator
// Watches the request and result channels and keeps its own skyline of every
// page. Each result is checked field by field against the predicted placement.
// ----------------------------------------------------------------------------
module sra_checker import sra_pkg::*; #(
  parameter int PAGE_WIDTH  = 128,
  parameter int PAGE_HEIGHT = 128,
  parameter int MAX_PAGES   = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [RECT_W-1:0]     rect_width,
  input  logic [RECT_W-1:0]     rect_height,
  input  logic                  done,
  input  logic                  granted,
  input  logic [PAGE_IDX_W-1:0] page_index,
  input  logic [POS_W-1:0]      pos_x,
  input  logic [POS_W-1:0]      pos_y,
  output int                    mismatches,
  output int                    outstanding,
  output int                    placed_count,
  output int                    refused_count,
  output int                    pages_used
);

  typedef struct packed {
    logic                  granted;
    logic [PAGE_IDX_W-1:0] page;
    logic [POS_W-1:0]      x;
    logic [POS_W-1:0]      y;
  } placement_t;

  int unsigned skyline [MAX_PAGES][PAGE_WIDTH];
  int unsigned pages_open;
  placement_t  placement_q [$];

  // Least-waste span on one page; lowest start column wins a tie.
  function automatic bit search_page(input int unsigned pg, input int unsigned w,
                                     input int unsigned h, output int unsigned fit_x,
                                     output int unsigned fit_y);
    int unsigned rest;
    int unsigned waste;
    int unsigned best_waste;
    int unsigned x;
    int unsigned i;
    bit          found;
    found      = 1'b0;
    best_waste = 0;
    fit_x      = 0;
    fit_y      = 0;
    for (x = 0; x + w <= PAGE_WIDTH; x++) begin
      rest = 0;
      for (i = 0; i < w; i++)
        if (skyline[pg][x+i] > rest) rest = skyline[pg][x+i];
      if (rest + h <= PAGE_HEIGHT) begin
        waste = 0;
        for (i = 0; i < w; i++) waste += rest - skyline[pg][x+i];
        if (!found || waste < best_waste) begin
          found      = 1'b1;
          best_waste = waste;
          fit_x      = x;
          fit_y      = rest;
        end
      end
    end
    return found;
  endfunction

  // Work out where a request lands and raise the skyline under it.
  function automatic placement_t place_request(input int unsigned w, input int unsigned h);
    placement_t  res;
    int unsigned pg;
    int unsigned fx;
    int unsigned fy;
    int unsigned i;
    bit          hit;
    res = '0;
    hit = 1'b0;
    fx  = 0;
    fy  = 0;
    pg  = 0;
    if (w == 0 || h == 0 || w > PAGE_WIDTH || h > PAGE_HEIGHT) return res;
    while (!hit && pg < pages_open) begin
      hit = search_page(pg, w, h, fx, fy);
      if (!hit) pg++;
    end
    if (!hit) begin
      if (pages_open >= MAX_PAGES) return res;
      pg = pages_open;
      pages_open++;
      fx = 0;
      fy = 0;
    end
    for (i = 0; i < w; i++) skyline[pg][fx+i] = fy + h;
    res.granted = 1'b1;
    res.page    = PAGE_IDX_W'(pg);
    res.x       = POS_W'(fx);
    res.y       = POS_W'(fy);
    return res;
  endfunction

  always @(posedge clk) begin
    placement_t want;
    if (rst) begin
      foreach (skyline[p, c]) skyline[p][c] = 0;
      pages_open = 0;
      placement_q.delete();
      mismatches    = 0;
      placed_count  = 0;
      refused_count = 0;
    end else begin
      // retire first: a result never belongs to a request accepted at the same edge
      if (done) begin
        if (placement_q.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = placement_q.pop_front();
          if (granted !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, granted);
            mismatches++;
          end
          if (page_index !== want.page) begin
            $error("page_index: expected %0d, got %0d", want.page, page_index);
            mismatches++;
          end
          if (pos_x !== want.x) begin
            $error("pos_x: expected %0d, got %0d", want.x, pos_x);
            mismatches++;
          end
          if (pos_y !== want.y) begin
            $error("pos_y: expected %0d, got %0d", want.y, pos_y);
            mismatches++;
          end
          if (want.granted) placed_count++;
          else refused_count++;
        end
      end
      if (start && !busy)
        placement_q.insert(placement_q.size(), place_request(rect_width, rect_height));
    end
    outstanding = placement_q.size();
    pages_used  = pages_open;
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - skyline rectangle allocator top-level test
// Drives directed and random rectangle requests with random idle bursts and
// hands the checking to sra_checker; reports the verdict at the end.
// ----------------------------------------------------------------------------
module testbench;
  import sra_pkg::*;

  localparam int PAGE_WIDTH      = 128;
  localparam int PAGE_HEIGHT     = 128;
  localparam int MAX_PAGES       = 4;
  localparam int RANDOM_REQUESTS = 800;
  localparam int CALM_TAIL       = 100;
  // worst request: a search over four pages plus the raise
  localparam int QUIET_LIMIT     = 100000;
  localparam int DRAIN_CYCLES    = 20;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  start       = 1'b0;
  logic [RECT_W-1:0]     rect_width  = '0;
  logic [RECT_W-1:0]     rect_height = '0;
  logic                  busy;
  logic                  done;
  logic                  granted;
  logic [PAGE_IDX_W-1:0] page_index;
  logic [POS_W-1:0]      pos_x;
  logic [POS_W-1:0]      pos_y;

  int mismatches;
  int outstanding;
  int placed_count;
  int refused_count;
  int pages_used;
  int sent_count   = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  skyline_rect_allocator_core #(
    .PAGE_WIDTH (PAGE_WIDTH),
    .PAGE_HEIGHT(PAGE_HEIGHT),
    .MAX_PAGES  (MAX_PAGES)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .rect_width (rect_width),
    .rect_height(rect_height),
    .done       (done),
    .granted    (granted),
    .page_index (page_index),
    .pos_x      (pos_x),
    .pos_y      (pos_y)
  );

  sra_checker #(
    .PAGE_WIDTH (PAGE_WIDTH),
    .PAGE_HEIGHT(PAGE_HEIGHT),
    .MAX_PAGES  (MAX_PAGES)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .done         (done),
    .granted      (granted),
    .page_index   (page_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .placed_count (placed_count),
    .refused_count(refused_count),
    .pages_used   (pages_used)
  );

  // count cycles in which neither a request nor a result moves
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present a request and hold it until the block takes it.
  task automatic issue_request(input int w, input int h);
    start       <= 1'b1;
    rect_width  <= RECT_W'(w);
    rect_height <= RECT_W'(h);
    do @(posedge clk); while (busy !== 1'b0);
    sent_count++;
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Mostly narrow spans: the search cost grows with the span width and with the number of start columns.
  function automatic int pick_width();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 62) return $urandom_range(1, 4);
    if (sel < 74) return $urandom_range(5, 16);
    if (sel < 86) return $urandom_range(100, PAGE_WIDTH);
    if (sel < 96) return $urandom_range(0, 255);
    return 0;
  endfunction

  function automatic int pick_height();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(1, PAGE_HEIGHT);
    if (sel < 85) return $urandom_range(1, 8);
    if (sel < 95) return $urandom_range(100, PAGE_HEIGHT);
    return $urandom_range(0, 255);
  endfunction

  initial begin
    int dir_w [] = '{1, 128, 0, 5, 129, 1, 255, 128, 64, 63, 2, 127,
                     128, 128, 1, 128, 1, 3, 2, 16, 100, 8};
    int dir_h [] = '{1, 128, 5, 0, 1, 129, 255, 1, 64, 17, 3, 1,
                     128, 128, 128, 60, 1, 2, 2, 40, 5, 8};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // fresh page, full page, zero and oversize fields, ties, page exhaustion
    foreach (dir_w[k]) issue_request(dir_w[k], dir_h[k]);
    drain_results();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      issue_request(pick_width(), pick_height());
      if (n % 200 == 199) drain_results();
      else if (n < RANDOM_REQUESTS - CALM_TAIL && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 18));
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d placed, %0d refused, %0d of %0d pages opened.",
             sent_count, placed_count, refused_count, pages_used, MAX_PAGES);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: skyline_rect_allocator_core.f
rtl/sra_pkg.sv
rtl/sra_ram.sv
rtl/sra_ctrl.sv
rtl/sra_dpath.sv
rtl/skyline_rect_allocator_core.sv
tb/sra_checker.sv
tb/testbench.sv
